### rtl/cover_motor_command_framer_core_defines.svh
// -----------------------------------------------------------------------------
// Assertion macros for the cover motor command framer
// Shared check templates, clocked on aclk and held off during reset.
// -----------------------------------------------------------------------------
`ifndef COVER_MOTOR_COMMAND_FRAMER_CORE_DEFINES_SVH
`define COVER_MOTOR_COMMAND_FRAMER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define CMFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cmfc: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define CMFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cmfc: next-cycle check failed");

`endif

### rtl/cmfc_pkg.sv
// -----------------------------------------------------------------------------
// cmfc_pkg
// Types, frame constants, CRC-16/Modbus byte update and the control store
// of the command framer.
// -----------------------------------------------------------------------------
package cmfc_pkg;

    // Frame constants
    localparam logic [7:0]  FRAME_SYNC   = 8'h55;
    localparam logic [7:0]  FRAME_KIND   = 8'h03;
    localparam logic [7:0]  CMD_OPEN     = 8'h01;
    localparam logic [7:0]  CMD_CLOSE    = 8'h02;
    localparam logic [7:0]  CMD_STOP     = 8'h03;
    localparam logic [7:0]  CMD_POSITION = 8'h04;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [6:0]  FULL_PERCENT = 7'd100;

    localparam int STEP_W = 3;

    typedef struct packed {
        logic       has_position;
        logic [6:0] position_percent;
        logic       stop_request;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       run_end;
    } out_item_t;

    // Which byte the datapath puts on the output
    typedef enum logic [2:0] {
        SEL_SYNC,
        SEL_ID_LO,
        SEL_ID_HI,
        SEL_KIND,
        SEL_CMD,
        SEL_ARG,
        SEL_CRC_LO,
        SEL_CRC_HI
    } byte_sel_t;

    // How the step counter moves after a step
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_SKIP_NO_ARG,
        JMP_END
    } jump_t;

    typedef struct packed {
        byte_sel_t         sel;
        logic              crc_upd;
        logic              frame_end;
        jump_t             jmp;
        logic [STEP_W-1:0] target;
    } ctl_word_t;

    // Control store: one word per frame byte
    function automatic ctl_word_t ctl_rom(input logic [STEP_W-1:0] step);
        ctl_word_t w;
        w = '{sel: SEL_SYNC, crc_upd: 1'b1, frame_end: 1'b0, jmp: JMP_NEXT,
              target: '0};
        unique case (step)
            3'd0: w.sel = SEL_SYNC;
            3'd1: w.sel = SEL_ID_LO;
            3'd2: w.sel = SEL_ID_HI;
            3'd3: w.sel = SEL_KIND;
            3'd4: begin
                w.sel    = SEL_CMD;
                w.jmp    = JMP_SKIP_NO_ARG;
                w.target = 3'd6;
            end
            3'd5: w.sel = SEL_ARG;
            3'd6: begin
                w.sel     = SEL_CRC_LO;
                w.crc_upd = 1'b0;
            end
            3'd7: begin
                w.sel       = SEL_CRC_HI;
                w.crc_upd   = 1'b0;
                w.frame_end = 1'b1;
                w.jmp       = JMP_END;
            end
        endcase
        return w;
    endfunction

    // Fold one byte into a reflected CRC-16 (poly 0xA001)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

### rtl/cmfc_microseq.sv
// -----------------------------------------------------------------------------
// cmfc_microseq
// Step counter over the control store; issues one control word per step.
// -----------------------------------------------------------------------------
module cmfc_microseq
    import cmfc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  logic      advance,
    input  logic      no_arg,
    output ctl_word_t ctl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctl = ctl_rom(step_reg);

    // Pick the next step from the jump field
    always_comb begin
        step_next = step_reg;
        if (start) begin
            step_next = '0;
        end else if (advance) begin
            unique case (ctl.jmp)
                JMP_NEXT:        step_next = step_reg + 1'b1;
                JMP_SKIP_NO_ARG: step_next = no_arg ? ctl.target : step_reg + 1'b1;
                JMP_END:         step_next = '0;
                default:         step_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

### rtl/cover_motor_command_framer_core.sv
// -----------------------------------------------------------------------------
// cover_motor_command_framer_core
// Builds the motor-cover command frames for one request, one byte per
// transfer, each frame closed by a CRC-16/Modbus, low byte first.
// -----------------------------------------------------------------------------
//  channel  ports                       moves
//  input    s_valid/s_ready/s_payload   one request (position, stop)
//  output   m_valid/m_ready/m_payload   one frame byte with end flags
//  config   cfg_wr_en/index/data        device id low (0), high (1)
//
//  A request is taken in its accept cycle; a frame has 7 or 8 bytes, and a
//  position plus stop sends two frames, paced by the microsequencer
//  stepping one control word per cycle while m_ready does not stall the
//  output. An empty request finishes in its accept cycle.
//  Reset (aresetn low, synchronous) clears the id registers and control.
//  A stall on m_ready freezes the sequencer; the next request is taken in
//  the cycle after the last byte enters the output register.
// -----------------------------------------------------------------------------
`include "cover_motor_command_framer_core_defines.svh"

module cover_motor_command_framer_core
    import cmfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_payload,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_index,
    input  logic [7:0] cfg_wr_data
);

    localparam logic [1:0] CFG_DEVICE_ID_LOW  = 2'd0;
    localparam logic [1:0] CFG_DEVICE_ID_HIGH = 2'd1;

    logic [7:0]  id_lo_reg;
    logic [7:0]  id_hi_reg;
    logic        busy_reg;
    logic [7:0]  cmd_reg;
    logic [6:0]  arg_reg;
    logic        with_arg_reg;
    logic        stop_pending_reg;
    logic [15:0] crc_reg;
    logic        m_valid_reg;
    out_item_t   m_payload_reg;

    ctl_word_t   ctl;
    logic        s_accept;
    logic        s_nonempty;
    logic        advance;
    logic        start;
    logic [7:0]  byte_mux;
    logic [6:0]  pct_sat;
    logic [7:0]  pos_cmd;

    assign s_ready    = !busy_reg;
    assign s_accept   = s_valid && s_ready;
    assign s_nonempty = s_payload.has_position || s_payload.stop_request;
    assign advance    = busy_reg && (!m_valid_reg || m_ready);
    assign start      = s_accept;
    assign m_valid    = m_valid_reg;
    assign m_payload  = m_payload_reg;

    cmfc_microseq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .advance (advance),
        .no_arg  (!with_arg_reg),
        .ctl     (ctl)
    );

    // Saturate percent and choose the position command
    always_comb begin
        pct_sat = (s_payload.position_percent > FULL_PERCENT) ?
                  FULL_PERCENT : s_payload.position_percent;
        priority if (pct_sat == FULL_PERCENT) begin
            pos_cmd = CMD_OPEN;
        end else if (pct_sat == 7'd0) begin
            pos_cmd = CMD_CLOSE;
        end else begin
            pos_cmd = CMD_POSITION;
        end
    end

    // Select the outgoing byte
    always_comb begin
        unique case (ctl.sel)
            SEL_SYNC:   byte_mux = FRAME_SYNC;
            SEL_ID_LO:  byte_mux = id_lo_reg;
            SEL_ID_HI:  byte_mux = id_hi_reg;
            SEL_KIND:   byte_mux = FRAME_KIND;
            SEL_CMD:    byte_mux = cmd_reg;
            SEL_ARG:    byte_mux = {1'b0, arg_reg};
            SEL_CRC_LO: byte_mux = crc_reg[7:0];
            SEL_CRC_HI: byte_mux = crc_reg[15:8];
            default:    byte_mux = FRAME_SYNC;
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_lo_reg <= '0;
            id_hi_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == CFG_DEVICE_ID_LOW) begin
                id_lo_reg <= cfg_wr_data;
            end
            if (cfg_wr_index == CFG_DEVICE_ID_HIGH) begin
                id_hi_reg <= cfg_wr_data;
            end
        end
    end

    // Request control, CRC and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            stop_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            // Load a new byte, or drop the output once it is transferred
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Load a request; an empty one causes no frame
            if (s_accept) begin
                crc_reg <= CRC_INIT;
                arg_reg <= pct_sat;
                if (s_payload.has_position) begin
                    busy_reg         <= 1'b1;
                    cmd_reg          <= pos_cmd;
                    with_arg_reg     <= (pos_cmd == CMD_POSITION);
                    stop_pending_reg <= s_payload.stop_request;
                end else if (s_payload.stop_request) begin
                    busy_reg         <= 1'b1;
                    cmd_reg          <= CMD_STOP;
                    with_arg_reg     <= 1'b0;
                    stop_pending_reg <= 1'b0;
                end
            end
            // Emit one byte per step
            if (advance) begin
                m_payload_reg.frame_byte   <= byte_mux;
                m_payload_reg.frame_end    <= ctl.frame_end;
                m_payload_reg.run_end      <= ctl.frame_end && !stop_pending_reg;
                if (ctl.crc_upd) begin
                    crc_reg <= crc_byte(crc_reg, byte_mux);
                end
                if (ctl.frame_end) begin
                    if (stop_pending_reg) begin
                        cmd_reg          <= CMD_STOP;
                        with_arg_reg     <= 1'b0;
                        stop_pending_reg <= 1'b0;
                        crc_reg          <= CRC_INIT;
                    end else begin
                        busy_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // Checks
    `CMFC_ASSERT_SAME(a_run_end_on_frame_end, m_valid && m_payload.run_end, m_payload.frame_end)
    `CMFC_ASSERT_NEXT(a_busy_after_request, s_accept && s_nonempty, !s_ready)
    `CMFC_ASSERT_SAME(a_idle_after_run_end, $fell(busy_reg), m_valid_reg && m_payload_reg.run_end)

endmodule
